>>> hw/rtl/arctangent_unit_macros.svh
// Assertion macros for the checker file of the arctangent unit.
`ifndef ARCTANGENT_UNIT_MACROS_SVH
`define ARCTANGENT_UNIT_MACROS_SVH

// Check a condition in the same cycle as its antecedent.
`define ATAN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its antecedent.
`define ATAN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/atan_pkg.sv
package atan_pkg;

    localparam int IN_W      = 32;
    localparam int OUT_W     = 30;
    localparam int IN_FB     = 16;
    localparam int OUT_FB    = 28;
    localparam int WF        = 30;
    localparam int OUT_SH    = WF - OUT_FB;
    localparam int TW        = 32;
    localparam int T2_W      = 31;
    localparam int YW        = 34;
    localparam int CD_W      = 26;
    localparam int DP_W      = CD_W + T2_W;

    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_Q_W   = 31;

    localparam longint PI12_Q  = 64'sd281104952;
    localparam longint PI6_Q   = 64'sd562209904;
    localparam longint PI3_Q   = 2 * PI6_Q;
    localparam longint PI2_Q   = 64'sd1686629713;
    localparam longint SQRT3_Q = 64'sd1859775393;
    localparam longint COEF_A  = 64'sd600368879;
    localparam longint COEF_B  = 64'sd1512667295;
    localparam longint COEF_C  = 64'sd647579911;
    localparam longint COEF_D  = 64'sd55409953;

    localparam longint ANGLE_RND = (PI2_Q + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
    localparam longint OUT_MAX_L = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [OUT_W-1:0] ANGLE_MAX =
        OUT_W'((ANGLE_RND > OUT_MAX_L) ? OUT_MAX_L : ANGLE_RND);

    // side data that travels with a request through every stage
    typedef struct packed {
        logic                 neg;
        logic                 recip;
        logic                 act;
        logic                 qneg;
        logic [1:0]           rot;
        logic signed [TW-1:0] t;
        logic [T2_W-1:0]      t2;
    } atan_tag_t;

endpackage

>>> hw/rtl/atan_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module atan_div
    import atan_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_v,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    input  atan_tag_t            tag_in,
    output logic                 out_v,
    output logic [DIV_Q_W-1:0]   quo,
    output atan_tag_t            tag_out
);

    logic                 v_reg    [DIV_Q_W];
    logic [DIV_DEN_W-1:0] rem_reg  [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   work_reg [DIV_Q_W];
    atan_tag_t            tag_reg  [DIV_Q_W];

    for (genvar k = 0; k < DIV_Q_W; k++)
    begin : g_bit
        logic                 v_src;
        logic [DIV_DEN_W-1:0] rem_src;
        logic [DIV_DEN_W-1:0] den_src;
        logic [DIV_Q_W-1:0]   work_src;
        atan_tag_t            tag_src;
        logic [DIV_DEN_W:0]   trial;
        logic                 ge;
        logic [DIV_DEN_W-1:0] rem_next;
        logic [DIV_Q_W-1:0]   work_next;

        if (k == 0)
        begin : g_head
            assign v_src    = in_v;
            assign rem_src  = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            assign den_src  = den;
            assign work_src = num[DIV_Q_W-1:0];
            assign tag_src  = tag_in;
        end
        else
        begin : g_body
            assign v_src    = v_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign work_src = work_reg[k-1];
            assign tag_src  = tag_reg[k-1];
        end

        always_comb
        begin
            trial     = {rem_src, work_src[DIV_Q_W-1]};
            ge        = (trial >= {1'b0, den_src});
            rem_next  = ge ? DIV_DEN_W'(trial - {1'b0, den_src}) : trial[DIV_DEN_W-1:0];
            work_next = {work_src[DIV_Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_src;
                work_reg[k] <= work_next;
                tag_reg[k]  <= tag_src;
            end
        end
    end

    assign out_v   = v_reg[DIV_Q_W-1];
    assign quo     = work_reg[DIV_Q_W-1];
    assign tag_out = tag_reg[DIV_Q_W-1];

endmodule

>>> hw/rtl/atan_rot.sv
// One conditional rotation by minus thirty degrees: multiply, divide, select.
module atan_rot
    import atan_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_v,
    input  atan_tag_t tag_in,
    output logic      out_v,
    output atan_tag_t tag_out
);

    localparam logic signed [TW-1:0]   PI12_T  = TW'(PI12_Q);
    localparam logic signed [TW-1:0]   SQRT3_T = TW'(SQRT3_Q);
    localparam logic signed [2*TW-1:0] ONE_SQ  = 64'sd1 <<< (2 * WF);

    logic                   m_v_reg;
    atan_tag_t              m_tag_reg;
    atan_tag_t              m_tag_next;
    logic signed [2*TW-1:0] m_prod_reg;
    logic signed [2*TW-1:0] m_prod_next;
    logic [DIV_DEN_W-1:0]   m_den_reg;
    logic [DIV_DEN_W-1:0]   m_den_next;

    logic [DIV_DEN_W-1:0]   half;
    logic                   qneg;
    logic [2*TW-1:0]        num_full;
    atan_tag_t              d_tag_in;

    logic                   d_v;
    logic [DIV_Q_W-1:0]     d_quo;
    atan_tag_t              d_tag;
    logic signed [TW-1:0]   q_s;

    logic                   s_v_reg;
    atan_tag_t              s_tag_reg;
    atan_tag_t              s_tag_next;

    always_comb
    begin
        m_tag_next     = tag_in;
        m_tag_next.act = (tag_in.t > PI12_T);
        m_prod_next    = tag_in.t * SQRT3_T;
        m_den_next     = DIV_DEN_W'(tag_in.t) + DIV_DEN_W'(SQRT3_Q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg <= in_v;
            s_v_reg <= d_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tag_reg  <= m_tag_next;
            m_prod_reg <= m_prod_next;
            m_den_reg  <= m_den_next;
            s_tag_reg  <= s_tag_next;
        end
    end

    // numerator magnitude of (t*sqrt3 - 1) with half the divisor for rounding
    always_comb
    begin
        half            = m_den_reg >> 1;
        qneg            = (m_prod_reg < ONE_SQ);
        num_full        = qneg ? (ONE_SQ - m_prod_reg + (2*TW)'(half))
                               : (m_prod_reg - ONE_SQ + (2*TW)'(half));
        d_tag_in        = m_tag_reg;
        d_tag_in.qneg   = qneg;
    end

    atan_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (m_v_reg),
        .num     (num_full[DIV_NUM_W-1:0]),
        .den     (m_den_reg),
        .tag_in  (d_tag_in),
        .out_v   (d_v),
        .quo     (d_quo),
        .tag_out (d_tag)
    );

    always_comb
    begin
        q_s        = signed'(TW'(d_quo));
        s_tag_next = d_tag;
        if (d_tag.act)
        begin
            s_tag_next.t   = d_tag.qneg ? -q_s : q_s;
            s_tag_next.rot = d_tag.rot + 2'd1;
        end
    end

    assign out_v   = s_v_reg;
    assign tag_out = s_tag_reg;

endmodule

>>> hw/rtl/arctangent_unit.sv
// Path: a request passes stage A, the reciprocal divider, stage B, both
// rotations, the polynomial stages and the output register to angle_valid.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a finished result waits on angle_ready.
// Reset: rst_n clears every valid bit at once; data registers are not reset.
module arctangent_unit
    import atan_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [IN_W-1:0]  x_value,
    input  logic                    x_valid,
    output logic                    x_ready,
    output logic signed [OUT_W-1:0] angle,
    output logic                    angle_valid,
    input  logic                    angle_ready
);

    // rounding helpers for the Q30 datapath
    localparam logic [2*TW-1:0]        HALF_U = 64'd1 << (WF - 1);
    localparam logic signed [2*TW-1:0] HALF_S = 64'sd1 <<< (WF - 1);
    localparam logic signed [YW-1:0]   HALF_O = YW'(64'sd1 <<< (OUT_SH - 1));
    localparam logic signed [YW-1:0]   OUT_HI = YW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [YW-1:0]   OUT_LO = -OUT_HI - YW'(1);
    localparam logic [CD_W-1:0]        COEF_D_U = CD_W'(COEF_D);

    logic en;

    // Stage A: capture the argument
    logic             a_v_reg;
    logic [IN_W-1:0]  a_x_reg;

    logic [IN_W-1:0]  mag_a;
    logic [2*TW-1:0]  t_shift;
    atan_tag_t        a_tag;
    logic [DIV_NUM_W-1:0] d1_num;

    logic             d1_v;
    logic [DIV_Q_W-1:0] d1_quo;
    atan_tag_t        d1_tag;

    // Stage B: pick reciprocal or scaled magnitude
    logic             b_v_reg;
    atan_tag_t        b_tag_reg;
    atan_tag_t        b_tag_next;

    logic             r1_v;
    atan_tag_t        r1_tag;
    logic             r2_v;
    atan_tag_t        r2_tag;

    // Polynomial stages
    logic                   p1_v_reg;
    atan_tag_t              p1_tag_reg;
    logic signed [2*TW-1:0] p1_sq_reg;
    logic signed [2*TW-1:0] p1_sq_next;

    logic                   p2_v_reg;
    atan_tag_t              p2_tag_reg;
    atan_tag_t              p2_tag_next;
    logic [2*TW-1:0]        sq_rnd;

    logic [DIV_DEN_W-1:0]   d4_den;
    logic [DIV_NUM_W-1:0]   d4_num;
    logic                   d4_v;
    logic [DIV_Q_W-1:0]     d4_quo;
    atan_tag_t              d4_tag;

    logic                   q1_v_reg;
    atan_tag_t              q1_tag_reg;
    logic [DIV_Q_W-1:0]     q1_q_reg;
    logic [DP_W-1:0]        q1_dp_reg;
    logic [DP_W-1:0]        q1_dp_next;

    logic                   q2_v_reg;
    atan_tag_t              q2_tag_reg;
    logic signed [TW-1:0]   q2_s_reg;
    logic signed [TW-1:0]   q2_s_next;
    logic [DP_W-1:0]        d_rnd;

    logic                   q3_v_reg;
    atan_tag_t              q3_tag_reg;
    logic signed [2*TW-1:0] q3_prod_reg;
    logic signed [2*TW-1:0] q3_prod_next;

    logic                   q4_v_reg;
    atan_tag_t              q4_tag_reg;
    logic signed [YW-1:0]   q4_y_reg;
    logic signed [YW-1:0]   q4_y_next;
    logic signed [2*TW-1:0] y_sum;

    logic                   q5_v_reg;
    atan_tag_t              q5_tag_reg;
    logic signed [YW-1:0]   q5_y_reg;
    logic signed [YW-1:0]   q5_y_next;

    logic                   q6_v_reg;
    atan_tag_t              q6_tag_reg;
    logic signed [YW-1:0]   q6_y_reg;
    logic signed [YW-1:0]   q6_y_next;

    logic                   q7_v_reg;
    atan_tag_t              q7_tag_reg;
    logic signed [YW-1:0]   q7_y_reg;
    logic signed [YW-1:0]   q7_y_next;
    logic signed [YW-1:0]   o_sum;

    logic signed [YW-1:0]   y_signed;
    logic                   out_v_reg;
    logic signed [OUT_W-1:0] angle_reg;
    logic signed [OUT_W-1:0] angle_next;

    // Advance everything whenever the output slot is free or being emptied.
    assign en          = !out_v_reg || angle_ready;
    assign x_ready     = en;
    assign angle_valid = out_v_reg;
    assign angle       = angle_reg;

    // Fold the sign off and prepare the reciprocal request.
    always_comb
    begin
        mag_a       = a_x_reg[IN_W-1] ? (~a_x_reg + IN_W'(1)) : a_x_reg;
        t_shift     = (2*TW)'(mag_a) << (WF - IN_FB);
        a_tag       = '0;
        a_tag.neg   = a_x_reg[IN_W-1];
        a_tag.recip = (mag_a > (IN_W'(1) << IN_FB));
        a_tag.t     = signed'(t_shift[TW-1:0]);
        d1_num      = (DIV_NUM_W'(1) << (IN_FB + WF)) + DIV_NUM_W'(mag_a >> 1);
    end

    atan_div u_div_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (a_v_reg),
        .num     (d1_num),
        .den     (DIV_DEN_W'(mag_a)),
        .tag_in  (a_tag),
        .out_v   (d1_v),
        .quo     (d1_quo),
        .tag_out (d1_tag)
    );

    always_comb
    begin
        b_tag_next = d1_tag;
        if (d1_tag.recip)
            b_tag_next.t = signed'(TW'(d1_quo));
    end

    // Two rotations bring any value in [0, 1] down to about pi/12.
    atan_rot u_rot_first (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (b_v_reg),
        .tag_in  (b_tag_reg),
        .out_v   (r1_v),
        .tag_out (r1_tag)
    );

    atan_rot u_rot_second (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (r1_v),
        .tag_in  (r1_tag),
        .out_v   (r2_v),
        .tag_out (r2_tag)
    );

    // Rational approximation t*(A/(B + t^2) + C - D*t^2).
    always_comb
    begin
        p1_sq_next     = r2_tag.t * r2_tag.t;
        sq_rnd         = (2*TW)'(p1_sq_reg) + HALF_U;
        p2_tag_next    = p1_tag_reg;
        p2_tag_next.t2 = T2_W'(sq_rnd >> WF);
        d4_den         = DIV_DEN_W'(COEF_B) + DIV_DEN_W'(p2_tag_reg.t2);
        d4_num         = (DIV_NUM_W'(COEF_A) << WF) + DIV_NUM_W'(d4_den >> 1);
        q1_dp_next     = DP_W'(COEF_D_U) * DP_W'(d4_tag.t2);
        d_rnd          = (q1_dp_reg + DP_W'(HALF_U)) >> WF;
        q2_s_next      = signed'(TW'(q1_q_reg) + TW'(COEF_C) - TW'(d_rnd));
        q3_prod_next   = q2_tag_reg.t * q2_s_reg;
    end

    atan_div u_div_poly (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (p2_v_reg),
        .num     (d4_num),
        .den     (d4_den),
        .tag_in  (p2_tag_reg),
        .out_v   (d4_v),
        .quo     (d4_quo),
        .tag_out (d4_tag)
    );

    // Round the core angle, add back the rotations, mirror reciprocals,
    // then round to the output format, restore the sign and saturate.
    always_comb
    begin
        y_sum     = q3_prod_reg + (q3_prod_reg[2*TW-1] ? (HALF_S - 64'sd1) : HALF_S);
        q4_y_next = YW'(y_sum >>> WF);
        q5_y_next = q4_y_reg + (q4_tag_reg.rot[1] ? YW'(PI3_Q)
                              : (q4_tag_reg.rot[0] ? YW'(PI6_Q) : YW'(0)));
        q6_y_next = q5_tag_reg.recip ? (YW'(PI2_Q) - q5_y_reg) : q5_y_reg;
        o_sum     = q6_y_reg + (q6_y_reg[YW-1] ? (HALF_O - YW'(1)) : HALF_O);
        q7_y_next = o_sum >>> OUT_SH;
        y_signed  = q7_tag_reg.neg ? -q7_y_reg : q7_y_reg;
        priority if (y_signed > OUT_HI)
            angle_next = OUT_W'(OUT_HI);
        else if (y_signed < OUT_LO)
            angle_next = OUT_W'(OUT_LO);
        else
            angle_next = OUT_W'(y_signed);
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            q1_v_reg  <= 1'b0;
            q2_v_reg  <= 1'b0;
            q3_v_reg  <= 1'b0;
            q4_v_reg  <= 1'b0;
            q5_v_reg  <= 1'b0;
            q6_v_reg  <= 1'b0;
            q7_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg   <= x_valid;
            b_v_reg   <= d1_v;
            p1_v_reg  <= r2_v;
            p2_v_reg  <= p1_v_reg;
            q1_v_reg  <= d4_v;
            q2_v_reg  <= q1_v_reg;
            q3_v_reg  <= q2_v_reg;
            q4_v_reg  <= q3_v_reg;
            q5_v_reg  <= q4_v_reg;
            q6_v_reg  <= q5_v_reg;
            q7_v_reg  <= q6_v_reg;
            out_v_reg <= q7_v_reg;
        end
    end

    // Payload: hold on stall, advance with the valid bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg     <= x_value;
            b_tag_reg   <= b_tag_next;
            p1_tag_reg  <= r2_tag;
            p1_sq_reg   <= p1_sq_next;
            p2_tag_reg  <= p2_tag_next;
            q1_tag_reg  <= d4_tag;
            q1_q_reg    <= d4_quo;
            q1_dp_reg   <= q1_dp_next;
            q2_tag_reg  <= q1_tag_reg;
            q2_s_reg    <= q2_s_next;
            q3_tag_reg  <= q2_tag_reg;
            q3_prod_reg <= q3_prod_next;
            q4_tag_reg  <= q3_tag_reg;
            q4_y_reg    <= q4_y_next;
            q5_tag_reg  <= q4_tag_reg;
            q5_y_reg    <= q5_y_next;
            q6_tag_reg  <= q5_tag_reg;
            q6_y_reg    <= q6_y_next;
            q7_tag_reg  <= q6_tag_reg;
            q7_y_reg    <= q7_y_next;
            angle_reg   <= angle_next;
        end
    end

endmodule

>>> hw/rtl/atan_checker.sv
`include "arctangent_unit_macros.svh"

module atan_checker
    import atan_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    x_ready,
    input logic signed [OUT_W-1:0] angle,
    input logic                    angle_valid,
    input logic                    angle_ready
);

    `ATAN_ASSERT_NOW(a_ready_tracks_output, 1'b1, x_ready == (!angle_valid || angle_ready), "x_ready does not follow the output slot")

    `ATAN_ASSERT_NEXT(a_result_held, angle_valid && !angle_ready, angle_valid && $stable(angle), "stalled result changed")

    `ATAN_ASSERT_NOW(a_angle_in_range, angle_valid, (angle <= ANGLE_MAX) && (angle >= -ANGLE_MAX), "angle outside plus or minus pi/2")

endmodule

bind arctangent_unit atan_checker u_atan_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .x_ready     (x_ready),
    .angle       (angle),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready)
);
